// ----- rtl/jih_pkg.sv -----
// Types and constants shared by the joint intensity histogram modules.
package jih_pkg;

    localparam int GREY_W  = 8;
    localparam int COORD_W = 12;
    localparam int DIM_W   = 13;
    localparam int COLOR_W = 8;
    localparam int RBIN_W  = 4;
    localparam int OUT_W   = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;

    localparam logic [1:0] REQ_ACCUM = 2'd0;
    localparam logic [1:0] REQ_CLEAR = 2'd1;
    localparam logic [1:0] REQ_READ  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BLUE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GREEN  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RED    = 3'd4;

    localparam logic [DIM_W-1:0]   WIDTH_RESET  = 13'd640;
    localparam logic [DIM_W-1:0]   HEIGHT_RESET = 13'd480;
    localparam logic [COLOR_W-1:0] BLUE_RESET   = 8'd255;
    localparam logic [COLOR_W-1:0] GREEN_RESET  = 8'd0;
    localparam logic [COLOR_W-1:0] RED_RESET    = 8'd0;

    typedef struct packed {
        logic [1:0]         req_type;
        logic [COORD_W-1:0] pixel_row;
        logic [COORD_W-1:0] pixel_col;
        logic [COLOR_W-1:0] rendered_blue;
        logic [COLOR_W-1:0] rendered_green;
        logic [COLOR_W-1:0] rendered_red;
        logic [GREY_W-1:0]  rendered_grey;
        logic [GREY_W-1:0]  video_grey;
        logic [RBIN_W-1:0]  read_rendered_bin;
        logic [RBIN_W-1:0]  read_video_bin;
    } jih_item_t;

    typedef struct packed {
        logic             sample_taken;
        logic [OUT_W-1:0] joint_count;
        logic [OUT_W-1:0] rendered_count;
        logic [OUT_W-1:0] video_count;
        logic [OUT_W-1:0] total_count;
    } jih_result_t;

    typedef struct packed {
        logic capture;
        logic lookup;
        logic sweep;
        logic commit;
    } jih_cmd_t;

    typedef struct packed {
        logic [1:0] req_type;
        logic       sweep_last;
        logic       out_blocked;
    } jih_status_t;

endpackage

// ----- rtl/jih_ctrl.sv -----
// Sequencing controller for the joint intensity histogram.
module jih_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  jih_pkg::jih_status_t status,
    output jih_pkg::jih_cmd_t    cmd
);
    import jih_pkg::*;

    localparam logic [2:0] ST_RST_CLR = 3'd0;
    localparam logic [2:0] ST_IDLE    = 3'd1;
    localparam logic [2:0] ST_LOOKUP  = 3'd2;
    localparam logic [2:0] ST_CLEAR   = 3'd3;
    localparam logic [2:0] ST_COMMIT  = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign in_stall = (state_reg != ST_IDLE);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_RST_CLR:
            begin
                cmd.sweep = 1'b1;
                if (status.sweep_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                cmd.lookup = 1'b1;
                if (status.req_type == REQ_CLEAR)
                begin
                    state_next = ST_CLEAR;
                end
                else
                begin
                    state_next = ST_COMMIT;
                end
            end
            ST_CLEAR:
            begin
                cmd.sweep = 1'b1;
                if (status.sweep_last)
                begin
                    state_next = ST_COMMIT;
                end
            end
            ST_COMMIT:
            begin
                if (!status.out_blocked)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_RST_CLR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_RST_CLR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> !status.out_blocked)
        else $error("result committed while output register is held");

    a_capture_lookup: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |=> state_reg == ST_LOOKUP)
        else $error("captured item not followed by lookup");

    a_sweep_state: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.sweep |-> (state_reg == ST_CLEAR || state_reg == ST_RST_CLR))
        else $error("clearing sweep outside a clearing state");

endmodule

// ----- rtl/jih_datapath.sv -----
// Datapath with histogram memories, marginal counters, total and result register.
module jih_datapath #(
    parameter int BINS_PER_AXIS = 16,
    parameter int COUNT_WIDTH   = 32
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  jih_pkg::jih_item_t                   in_data,
    input  logic                                 cfg_we,
    input  logic [jih_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [jih_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  jih_pkg::jih_cmd_t                    cmd,
    output jih_pkg::jih_status_t                 status,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output jih_pkg::jih_result_t                 out_data
);
    import jih_pkg::*;

    localparam int BIN_W   = $clog2(BINS_PER_AXIS);
    localparam int JDEPTH  = BINS_PER_AXIS * BINS_PER_AXIS;
    localparam int JADDR_W = $clog2(JDEPTH);
    localparam int PROD_W  = GREY_W + $clog2(BINS_PER_AXIS + 1);

    function automatic logic [BIN_W-1:0] wrap_bin(input logic [RBIN_W-1:0] v);
        logic [8:0] r;
        r = 9'(v);
        for (int i = 0; i < 8; i++)
        begin
            if (r >= 9'(BINS_PER_AXIS))
            begin
                r = r - 9'(BINS_PER_AXIS);
            end
        end
        return BIN_W'(r);
    endfunction

    function automatic logic [COUNT_WIDTH-1:0] bump(input logic [COUNT_WIDTH-1:0] c);
        return (c == '1) ? c : c + COUNT_WIDTH'(1);
    endfunction

    // Configuration registers.
    logic [DIM_W-1:0]   width_reg, width_next;
    logic [DIM_W-1:0]   height_reg, height_next;
    logic [COLOR_W-1:0] blue_reg, blue_next;
    logic [COLOR_W-1:0] green_reg, green_next;
    logic [COLOR_W-1:0] red_reg, red_next;

    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        blue_next   = blue_reg;
        green_next  = green_reg;
        red_next    = red_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_WIDTH:  width_next  = cfg_data;
                CFG_HEIGHT: height_next = cfg_data;
                CFG_BLUE:   blue_next   = cfg_data[COLOR_W-1:0];
                CFG_GREEN:  green_next  = cfg_data[COLOR_W-1:0];
                CFG_RED:    red_next    = cfg_data[COLOR_W-1:0];
                default:    width_next  = width_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
            blue_reg   <= BLUE_RESET;
            green_reg  <= GREEN_RESET;
            red_reg    <= RED_RESET;
        end
        else
        begin
            width_reg  <= width_next;
            height_reg <= height_next;
            blue_reg   <= blue_next;
            green_reg  <= green_next;
            red_reg    <= red_next;
        end
    end

    // Captured item and bin addressing.
    jih_item_t item_reg, item_next;

    assign item_next = cmd.capture ? in_data : item_reg;

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
    end

    logic [PROD_W-1:0]  rprod, vprod;
    logic [BIN_W-1:0]   abin, bbin;
    logic [JADDR_W-1:0] jaddr;
    logic               is_read;

    assign rprod   = PROD_W'(item_reg.rendered_grey) * PROD_W'(BINS_PER_AXIS);
    assign vprod   = PROD_W'(item_reg.video_grey) * PROD_W'(BINS_PER_AXIS);
    assign is_read = (item_reg.req_type == REQ_READ);
    assign abin    = is_read ? wrap_bin(item_reg.read_rendered_bin) : BIN_W'(rprod >> GREY_W);
    assign bbin    = is_read ? wrap_bin(item_reg.read_video_bin) : BIN_W'(vprod >> GREY_W);
    assign jaddr   = JADDR_W'(JADDR_W'(abin) * JADDR_W'(BINS_PER_AXIS)) + JADDR_W'(bbin);

    // Pixel eligibility: accumulate items off the border and not background colored.
    logic [DIM_W-1:0] row_ext, col_ext;
    logic             row_in, col_in, fg, elig;
    logic             counted_reg, counted_next;

    assign row_ext = DIM_W'(item_reg.pixel_row);
    assign col_ext = DIM_W'(item_reg.pixel_col);
    assign row_in  = (row_ext != '0) && (row_ext < height_reg)
                     && (row_ext != height_reg - DIM_W'(1));
    assign col_in  = (col_ext != '0) && (col_ext < width_reg)
                     && (col_ext != width_reg - DIM_W'(1));
    assign fg      = (item_reg.rendered_blue != blue_reg)
                     || (item_reg.rendered_green != green_reg)
                     || (item_reg.rendered_red != red_reg);
    assign elig    = row_in && col_in && fg && (item_reg.req_type == REQ_ACCUM);

    assign counted_next = cmd.lookup ? elig : counted_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            counted_reg <= 1'b0;
        end
        else
        begin
            counted_reg <= counted_next;
        end
    end

    // Clearing sweep counter.
    logic [JADDR_W-1:0] sweep_reg, sweep_next;
    logic               sweep_last;

    assign sweep_last = (sweep_reg == JADDR_W'(JDEPTH - 1));
    assign sweep_next = !cmd.sweep ? sweep_reg :
                        (sweep_last ? '0 : sweep_reg + JADDR_W'(1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sweep_reg <= '0;
        end
        else
        begin
            sweep_reg <= sweep_next;
        end
    end

    // Memories.
    logic [COUNT_WIDTH-1:0] joint_mem [JDEPTH];
    logic [COUNT_WIDTH-1:0] ren_mem [BINS_PER_AXIS];
    logic [COUNT_WIDTH-1:0] vid_mem [BINS_PER_AXIS];
    logic [COUNT_WIDTH-1:0] joint_rd_reg, ren_rd_reg, vid_rd_reg;

    logic                   bump_en, marg_clr;
    logic                   jwe, mwe;
    logic [JADDR_W-1:0]     jwaddr;
    logic [BIN_W-1:0]       rwaddr, vwaddr;
    logic [COUNT_WIDTH-1:0] jwdata, rwdata, vwdata;

    assign bump_en  = cmd.commit && counted_reg;
    assign marg_clr = cmd.sweep && (sweep_reg < JADDR_W'(BINS_PER_AXIS));
    assign jwe      = cmd.sweep || bump_en;
    assign mwe      = marg_clr || bump_en;
    assign jwaddr   = cmd.sweep ? sweep_reg : jaddr;
    assign rwaddr   = cmd.sweep ? sweep_reg[BIN_W-1:0] : abin;
    assign vwaddr   = cmd.sweep ? sweep_reg[BIN_W-1:0] : bbin;
    assign jwdata   = cmd.sweep ? '0 : bump(joint_rd_reg);
    assign rwdata   = cmd.sweep ? '0 : bump(ren_rd_reg);
    assign vwdata   = cmd.sweep ? '0 : bump(vid_rd_reg);

    always_ff @(posedge clk)
    begin
        if (jwe)
        begin
            joint_mem[jwaddr] <= jwdata;
        end
        joint_rd_reg <= joint_mem[jaddr];
    end

    always_ff @(posedge clk)
    begin
        if (mwe)
        begin
            ren_mem[rwaddr] <= rwdata;
        end
        ren_rd_reg <= ren_mem[abin];
    end

    always_ff @(posedge clk)
    begin
        if (mwe)
        begin
            vid_mem[vwaddr] <= vwdata;
        end
        vid_rd_reg <= vid_mem[bbin];
    end

    // Total sample count.
    logic [COUNT_WIDTH-1:0] total_reg, total_next;

    assign total_next = cmd.sweep ? '0 : (bump_en ? bump(total_reg) : total_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg <= '0;
        end
        else
        begin
            total_reg <= total_next;
        end
    end

    // Result register.
    jih_result_t result;
    jih_result_t out_reg, out_next;
    logic        out_valid_reg, out_valid_next;
    logic        out_blocked;

    always_comb
    begin
        result = '0;
        if (item_reg.req_type == REQ_ACCUM)
        begin
            result.sample_taken = counted_reg;
        end
        else if (is_read)
        begin
            result.joint_count    = OUT_W'(joint_rd_reg);
            result.rendered_count = OUT_W'(ren_rd_reg);
            result.video_count    = OUT_W'(vid_rd_reg);
            result.total_count    = OUT_W'(total_reg);
        end
    end

    assign out_blocked    = out_valid_reg && out_stall;
    assign out_valid_next = cmd.commit || out_blocked;
    assign out_next       = cmd.commit ? result : out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    assign status.req_type    = item_reg.req_type;
    assign status.sweep_last  = sweep_last;
    assign status.out_blocked = out_blocked;

    a_taken_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.sample_taken) |->
        (out_reg.joint_count == '0 && out_reg.total_count == '0))
        else $error("counted pixel result carries nonzero counts");

    a_bin_le_total: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.commit && is_read) |->
        (joint_rd_reg <= total_reg && ren_rd_reg <= total_reg && vid_rd_reg <= total_reg))
        else $error("bin count exceeds total sample count");

    a_sweep_total: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.sweep |=> total_reg == '0)
        else $error("total not cleared by sweep");

endmodule

// ----- rtl/joint_intensity_histogram.sv -----
// Top level of the joint intensity histogram block.
// Accumulate and read items pass through accept, memory lookup and commit in turn; the lookup
// step covers the registered read of the joint histogram memory ahead of its read-modify-write;
// a clear item adds a clearing pass between lookup and commit that writes one joint entry per
// cycle, and after reset the same pass runs over every joint entry with in_stall high.
// A commit also waits while the previous result beat is still stalled.
// Configuration writes are always taken (cfg_ready is high); write them only while the block is idle.
module joint_intensity_histogram #(
    parameter int BINS_PER_AXIS = 16,
    parameter int COUNT_WIDTH   = 32
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  jih_pkg::jih_item_t             in_data,
    output logic                           out_valid,
    input  logic                           out_stall,
    output jih_pkg::jih_result_t           out_data,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [jih_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [jih_pkg::CFG_DATA_W-1:0] cfg_data
);
    import jih_pkg::*;

    jih_cmd_t    cmd;
    jih_status_t status;
    logic        cfg_we;

    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;

    jih_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    jih_datapath #(
        .BINS_PER_AXIS (BINS_PER_AXIS),
        .COUNT_WIDTH   (COUNT_WIDTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule
